@@ design/lcd4_pkg.sv @@
package lcd4_pkg;

   // Defaults for the geometry of the panel.
   localparam int DEF_LINE_WIDTH = 16;
   localparam int DEF_LINE_COUNT = 2;

   // Request codes.
   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_START     = 3'd2,
      OP_TEXT_CHAR = 3'd3,
      OP_RAW_CHAR  = 3'd4,
      OP_LIGHT     = 3'd5
   } opcode_type;

   // What sort of step sequence the datapath is playing out.
   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_LIGHT = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Panel command bytes and nibbles.
   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [6:0] DDRAM_ADDR_MASK = 7'h7f;
   localparam logic [6:0] ROW1_OFFSET     = 7'h40;
   localparam logic [3:0] NIB_WAKE        = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISP_ON     = 8'h0C;

   localparam logic [4:0] WAIT_POWER_UP   = 5'd16;
   localparam logic [4:0] WAIT_FIRST_WAKE = 5'd5;
   localparam logic [4:0] WAIT_WAKE       = 5'd1;
   localparam logic [4:0] WAIT_CLEAR      = 5'd2;
   localparam logic [4:0] WAIT_NONE       = 5'd0;

   // Index of the final step of each sequence.
   localparam logic [3:0] INIT_LAST_STEP  = 4'd14;
   localparam logic [3:0] BYTE_LAST_STEP  = 4'd1;
   localparam logic [3:0] LIGHT_LAST_STEP = 4'd0;

   typedef struct packed {
      logic [3:0] nibble;
      logic       strobe;
      logic [4:0] wait_ms;
   } step_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_req;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_steps;
      logic final_step;
      logic slot_free;
   } stat_type;

   // Power-on sequence of the panel, one entry per pin step.
   function automatic step_type init_step(input logic [3:0] idx);
      step_type s;
      s.strobe  = 1'b1;
      s.wait_ms = WAIT_NONE;
      s.nibble  = 4'h0;
      unique case (idx)
         4'd0: begin
            s.strobe  = 1'b0;
            s.wait_ms = WAIT_POWER_UP;
         end
         4'd1: begin
            s.nibble  = NIB_WAKE;
            s.wait_ms = WAIT_FIRST_WAKE;
         end
         4'd2, 4'd3: begin
            s.nibble  = NIB_WAKE;
            s.wait_ms = WAIT_WAKE;
         end
         4'd4: begin
            s.nibble  = NIB_FOUR_BIT;
            s.wait_ms = WAIT_WAKE;
         end
         4'd5:  s.nibble = CMD_FUNC_SET[7:4];
         4'd6:  s.nibble = CMD_FUNC_SET[3:0];
         4'd7:  s.nibble = CMD_DISP_OFF[7:4];
         4'd8:  s.nibble = CMD_DISP_OFF[3:0];
         4'd9:  s.nibble = CMD_CLEAR[7:4];
         4'd10: begin
            s.nibble  = CMD_CLEAR[3:0];
            s.wait_ms = WAIT_CLEAR;
         end
         4'd11: s.nibble = CMD_ENTRY_MODE[7:4];
         4'd12: s.nibble = CMD_ENTRY_MODE[3:0];
         4'd13: s.nibble = CMD_DISP_ON[7:4];
         4'd14: s.nibble = CMD_DISP_ON[3:0];
         default: begin
            s.strobe = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

@@ design/lcd4_req_if.sv @@
interface lcd4_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        opcode;
   logic signed [7:0] column;
   logic signed [7:0] row;
   logic [7:0]        char_code;
   logic              backlight_on;

   modport source (output valid, opcode, column, row, char_code, backlight_on,
                   input ready);
   modport sink (input valid, opcode, column, row, char_code, backlight_on,
                 output ready);
endinterface

@@ design/lcd4_rsp_if.sv @@
interface lcd4_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] nibble;
   logic       reg_select;
   logic       read_write;
   logic       backlight;
   logic       strobe_res;
   logic [4:0] wait_after_ms;
   logic       last;

   modport source (output valid, nibble, reg_select, read_write, backlight,
                   strobe_res, wait_after_ms, last, input ready);
   modport sink (input valid, nibble, reg_select, read_write, backlight,
                 strobe_res, wait_after_ms, last, output ready);
endinterface

@@ design/lcd4_controller.sv @@
module lcd4_controller import lcd4_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.take_req  = 1'b0;
      cmd.emit_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid && stat.has_steps) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit_step = stat.slot_free;
            if (stat.slot_free && stat.final_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/lcd4_datapath.sv @@
module lcd4_datapath import lcd4_pkg::*; #(
   parameter int LINE_WIDTH = DEF_LINE_WIDTH,
   parameter int LINE_COUNT = DEF_LINE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_opcode,
   input  logic signed [7:0] req_column,
   input  logic signed [7:0] req_row,
   input  logic [7:0]        req_char_code,
   input  logic              req_backlight_on,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [3:0]        rsp_nibble,
   output logic              rsp_reg_select,
   output logic              rsp_read_write,
   output logic              rsp_backlight,
   output logic              rsp_strobe_res,
   output logic [4:0]        rsp_wait_after_ms,
   output logic              rsp_last
);

   localparam int CL_W = $clog2(LINE_WIDTH + 1);

   // Persistent state of the driver.
   logic            light_ff, light_in;
   logic [CL_W-1:0] cols_ff, cols_in;

   // Current sequence.
   kind_type   kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       rs_ff, rs_in;
   logic [4:0] wait_ff, wait_in;
   logic [3:0] step_ff;
   logic [3:0] last_idx_ff, last_idx_in;
   logic       has_steps;

   // Output register.
   logic       rsp_valid_ff;
   logic [3:0] nibble_ff;
   logic       rs_out_ff;
   logic       light_out_ff;
   logic       strobe_ff;
   logic [4:0] wait_out_ff;
   logic       last_ff;

   logic       col_ok, row_ok;
   logic [6:0] addr;
   step_type   rom_step, cur_step;
   logic       cur_rs;

   assign col_ok = !req_column[7] && (req_column[6:0] < 7'(LINE_WIDTH));
   assign row_ok = !req_row[7] && (req_row[6:0] < 7'(LINE_COUNT));
   assign addr   = (req_row[0] ? ROW1_OFFSET : 7'h00) + req_column[6:0];

   // Decode of the request presented on the input channel.
   always_comb begin
      kind_in     = KIND_BYTE;
      byte_in     = req_char_code;
      rs_in       = 1'b1;
      wait_in     = WAIT_NONE;
      last_idx_in = BYTE_LAST_STEP;
      has_steps   = 1'b0;
      cols_in     = cols_ff;
      light_in    = light_ff;
      unique case (opcode_type'(req_opcode))
         OP_INIT: begin
            kind_in     = KIND_INIT;
            rs_in       = 1'b0;
            last_idx_in = INIT_LAST_STEP;
            has_steps   = 1'b1;
         end
         OP_CLEAR: begin
            byte_in   = CMD_CLEAR;
            rs_in     = 1'b0;
            wait_in   = WAIT_CLEAR;
            has_steps = 1'b1;
         end
         OP_START: begin
            rs_in   = 1'b0;
            byte_in = CMD_SET_DDRAM | {1'b0, addr & DDRAM_ADDR_MASK};
            if (col_ok && row_ok) begin
               has_steps = 1'b1;
               cols_in   = CL_W'(LINE_WIDTH) - CL_W'(req_column[6:0]);
            end else begin
               cols_in = '0;
            end
         end
         OP_TEXT_CHAR: begin
            if (req_char_code == 8'h00) begin
               cols_in = '0;
            end else if (cols_ff != '0) begin
               cols_in   = cols_ff - CL_W'(1);
               has_steps = 1'b1;
            end
         end
         OP_RAW_CHAR: begin
            has_steps = 1'b1;
         end
         OP_LIGHT: begin
            kind_in     = KIND_LIGHT;
            rs_in       = 1'b0;
            last_idx_in = LIGHT_LAST_STEP;
            light_in    = req_backlight_on;
            has_steps   = 1'b1;
         end
         default: begin
            has_steps = 1'b0;
         end
      endcase
   end

   // Pin step for the current step index.
   assign rom_step = init_step(step_ff);

   always_comb begin
      cur_step = rom_step;
      cur_rs   = 1'b0;
      case (kind_ff)
         KIND_INIT: begin
            cur_step = rom_step;
         end
         KIND_BYTE: begin
            cur_rs          = rs_ff;
            cur_step.strobe = 1'b1;
            if (step_ff[0]) begin
               cur_step.nibble  = byte_ff[3:0];
               cur_step.wait_ms = wait_ff;
            end else begin
               cur_step.nibble  = byte_ff[7:4];
               cur_step.wait_ms = WAIT_NONE;
            end
         end
         default: begin
            cur_step.nibble  = 4'h0;
            cur_step.strobe  = 1'b0;
            cur_step.wait_ms = WAIT_NONE;
         end
      endcase
   end

   assign stat.has_steps  = has_steps;
   assign stat.final_step = (step_ff == last_idx_ff);
   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff     <= 1'b0;
         cols_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_req) begin
            light_ff <= light_in;
            cols_ff  <= cols_in;
         end
         if (cmd.emit_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         kind_ff     <= kind_in;
         byte_ff     <= byte_in;
         rs_ff       <= rs_in;
         wait_ff     <= wait_in;
         last_idx_ff <= last_idx_in;
         step_ff     <= 4'd0;
      end else if (cmd.emit_step) begin
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.emit_step) begin
         nibble_ff    <= cur_step.nibble;
         rs_out_ff    <= cur_rs;
         light_out_ff <= light_ff;
         strobe_ff    <= cur_step.strobe;
         wait_out_ff  <= cur_step.wait_ms;
         last_ff      <= stat.final_step;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nibble        = nibble_ff;
   assign rsp_reg_select    = rs_out_ff;
   assign rsp_read_write    = 1'b0;
   assign rsp_backlight     = light_out_ff;
   assign rsp_strobe_res    = strobe_ff;
   assign rsp_wait_after_ms = wait_out_ff;
   assign rsp_last          = last_ff;

endmodule

@@ design/char_lcd_4bit_interface.sv @@
// Character LCD driver for a panel wired on a 4-bit data bus.
// The req_chan channel takes one request per transfer: initialise, clear,
// start text at a column and row, a text character, a raw character or a
// backlight level. The rsp_chan channel gives one pin step per transfer:
// the nibble for DB7..DB4, RS, RW, the backlight level, whether enable is
// to be pulsed, and how many milliseconds a downstream timer must wait
// afterwards. The final step of a request carries last.
// A request is taken in the idle state; its steps follow at one per cycle
// from the step counter in the datapath while the receiver keeps the output
// register free: the whole power-on table for initialisation, two nibbles
// for a byte and one step for a backlight change. The first step is loaded
// once the controller has entered its run state. A request that causes no
// steps (a rejected start of text, a dropped or terminating text character,
// an unused code) leaves the controller idle. A new request is taken while
// the final step still waits in the output register.
// When the receiver stalls, the output register holds its step and the
// sequence pauses until the transfer completes. Reset switches the
// backlight off and leaves no columns free for text.
module char_lcd_4bit_interface import lcd4_pkg::*; #(
   parameter int LINE_WIDTH = DEF_LINE_WIDTH,
   parameter int LINE_COUNT = DEF_LINE_COUNT
) (
   input logic        clock,
   input logic        reset,
   lcd4_req_if.sink   req_chan,
   lcd4_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences requests; it only sees the handshake and the
   // status word from the datapath.
   lcd4_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath decodes requests, holds the text and backlight state and
   // builds each pin step into the output register.
   lcd4_datapath #(
      .LINE_WIDTH (LINE_WIDTH),
      .LINE_COUNT (LINE_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_chan.opcode),
      .req_column        (req_chan.column),
      .req_row           (req_chan.row),
      .req_char_code     (req_chan.char_code),
      .req_backlight_on  (req_chan.backlight_on),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_nibble        (rsp_chan.nibble),
      .rsp_reg_select    (rsp_chan.reg_select),
      .rsp_read_write    (rsp_chan.read_write),
      .rsp_backlight     (rsp_chan.backlight),
      .rsp_strobe_res    (rsp_chan.strobe_res),
      .rsp_wait_after_ms (rsp_chan.wait_after_ms),
      .rsp_last          (rsp_chan.last)
   );

   // A step is never loaded over a result that has not yet been transferred.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("step loaded over a pending result");

   // Taking a request and emitting a step never happen in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_req && cmd.emit_step))
      else $error("request taken while a sequence is running");

   // A request without steps leaves the block ready in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take_req && !stat.has_steps) |=> req_chan.ready)
      else $error("empty request did not return to idle");

   // The final step of a sequence is presented with last set.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step && stat.final_step) |=> (rsp_chan.valid && rsp_chan.last))
      else $error("final step presented without last");

endmodule
